### design/rle_pkg.sv
// Package for the run-length Elias encoder: widths, codeword modes, beat types and log helper.
package rle_pkg;

  localparam int RUN_WIDTH = 32;
  localparam int EXT_W     = RUN_WIDTH + 1;
  localparam int LOG_W     = $clog2(EXT_W + 1);
  localparam int CODE_W    = 63;
  localparam int LEN_W     = 6;
  localparam int MODE_W    = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_GAMMA = 2'd0,
    MODE_DELTA = 2'd1,
    MODE_PLUS1 = 2'd2
  } code_mode_t;

  typedef struct packed {
    logic                 hdr;
    logic [RUN_WIDTH-1:0] n;
    logic                 ovf;
    logic                 last;
  } run_desc_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              hdr;
    logic              last;
    logic              ovf;
  } code_result_t;

  function automatic logic [LOG_W-1:0] flog2(input logic [EXT_W-1:0] x);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int i = 1; i < EXT_W; i++) begin
      if (x[i]) r = LOG_W'(i);
    end
    return r;
  endfunction

endpackage

### design/rle_encode.sv
// Codeword builder: turns one run descriptor into a gamma, delta or plus-one codeword, or a one-bit header.
module rle_encode (
  input  logic [rle_pkg::MODE_W-1:0] mode,
  input  rle_pkg::run_desc_t  desc,
  output rle_pkg::code_result_t res
);
  import rle_pkg::*;

  logic [RUN_WIDTH-1:0] nn;
  logic [EXT_W-1:0]     n_ext;
  logic [EXT_W-1:0]     m_ext;
  logic [LOG_W-1:0]     l;
  logic [LOG_W-1:0]     g;
  logic [LOG_W-1:0]     lg;
  logic [LOG_W-1:0]     b;
  logic [LOG_W-1:0]     lb;

  always_comb begin
    nn    = (desc.n == '0) ? RUN_WIDTH'(1) : desc.n;
    n_ext = EXT_W'(nn);
    m_ext = n_ext + EXT_W'(1);
    l     = flog2(n_ext);
    g     = l + LOG_W'(1);
    lg    = flog2(EXT_W'(g));
    b     = flog2(m_ext);
    lb    = flog2(EXT_W'(b));

    res.hdr  = desc.hdr;
    res.last = desc.last;
    res.ovf  = desc.hdr ? 1'b0 : desc.ovf;

    if (desc.hdr) begin
      res.bits = CODE_W'(desc.n[0]);
      res.len  = LEN_W'(1);
    end else begin
      case (code_mode_t'(mode))
        MODE_DELTA: begin
          res.bits = (CODE_W'(g) << l)
                   | (CODE_W'(nn) & ((CODE_W'(1) << l) - CODE_W'(1)));
          res.len  = LEN_W'({lg, 1'b1}) + LEN_W'(l);
        end
        MODE_PLUS1: begin
          res.bits = (CODE_W'(b) << b)
                   | (CODE_W'(m_ext) & ((CODE_W'(1) << b) - CODE_W'(1)));
          res.len  = LEN_W'({lb, 1'b1}) + LEN_W'(b);
        end
        default: begin
          res.bits = CODE_W'(nn);
          res.len  = LEN_W'({l, 1'b1});
        end
      endcase
    end
  end

endmodule

### design/run_length_elias_encoder.sv
// Top level of the run-length Elias encoder: run tracking, result queue and output register.
// With the queue empty, an accepted source bit's result is registered in the queue, then in the output register.
// Throughput: one source bit per cycle while out_stall is low and each bit gives at most one result;
// a bit that gives two results has them leave one at a time through the single output register.
// The input stalls while the four-entry result queue has fewer than two free slots.
// Reset (synchronous, rst_n low): run state cleared, queue and output empty, mode gamma.
module run_length_elias_encoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_src_bit,
  input  logic                         in_end_of_stream,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rle_pkg::CODE_W-1:0]   out_code_bits,
  output logic [rle_pkg::LEN_W-1:0]    out_code_length,
  output logic                         out_is_header,
  output logic                         out_last,
  output logic                         out_run_overflow,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rle_pkg::MODE_W-1:0]   cfg_code_mode
);
  import rle_pkg::*;

  logic                 run_value_r, run_value_nxt;
  logic [RUN_WIDTH-1:0] run_len_r, run_len_nxt;
  logic                 started_r, started_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [MODE_W-1:0]    mode_r;

  run_desc_t            q_r [QDEPTH];
  logic [QPTR_W-1:0]    head_r, tail_r;
  logic [QCNT_W-1:0]    count_r, count_nxt;

  run_desc_t            pend [2];
  logic [1:0]           np;
  logic                 in_acc;
  logic                 pop;
  code_result_t         enc;
  code_result_t         out_r;
  logic                 out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count_r > QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign pop       = (count_r != '0) && (!out_valid_r || !out_stall);

  always_comb begin
    run_value_nxt = run_value_r;
    run_len_nxt   = run_len_r;
    started_nxt   = started_r;
    ovf_nxt       = ovf_r;
    np            = 2'd0;
    pend[0]       = '0;
    pend[1]       = '0;
    if (in_acc) begin
      if (!started_r) begin
        pend[0]       = '{hdr: 1'b1, n: RUN_WIDTH'(in_src_bit), ovf: 1'b0, last: 1'b0};
        np            = 2'd1;
        run_value_nxt = in_src_bit;
        run_len_nxt   = RUN_WIDTH'(1);
        ovf_nxt       = 1'b0;
        started_nxt   = 1'b1;
      end else if (in_src_bit == run_value_r) begin
        if (run_len_r == '1) begin
          ovf_nxt = 1'b1;
        end else begin
          run_len_nxt = run_len_r + RUN_WIDTH'(1);
        end
      end else begin
        pend[0]       = '{hdr: 1'b0, n: run_len_r, ovf: ovf_r, last: 1'b0};
        np            = 2'd1;
        run_value_nxt = in_src_bit;
        run_len_nxt   = RUN_WIDTH'(1);
        ovf_nxt       = 1'b0;
      end
      if (in_end_of_stream) begin
        pend[np[0]] = '{hdr: 1'b0, n: run_len_nxt, ovf: ovf_nxt, last: 1'b1};
        np          = np + 2'd1;
        started_nxt = 1'b0;
        run_len_nxt = '0;
        ovf_nxt     = 1'b0;
      end
    end
    count_nxt = count_r + QCNT_W'(np) - QCNT_W'(pop);
  end

  rle_encode u_encode (
    .mode (mode_r),
    .desc (q_r[head_r]),
    .res  (enc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r <= 1'b0;
      run_len_r   <= '0;
      started_r   <= 1'b0;
      ovf_r       <= 1'b0;
      mode_r      <= MODE_GAMMA;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_value_r <= run_value_nxt;
      run_len_r   <= run_len_nxt;
      started_r   <= started_nxt;
      ovf_r       <= ovf_nxt;
      count_r     <= count_nxt;
      tail_r      <= tail_r + QPTR_W'(np);
      if (cfg_valid && cfg_ready) mode_r <= cfg_code_mode;
      if (pop) begin
        head_r      <= head_r + QPTR_W'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (np != 2'd0) q_r[tail_r] <= pend[0];
    if (np == 2'd2) q_r[tail_r + QPTR_W'(1)] <= pend[1];
    if (pop) out_r <= enc;
  end

  assign out_valid        = out_valid_r;
  assign out_code_bits    = out_r.bits;
  assign out_code_length  = out_r.len;
  assign out_is_header    = out_r.hdr;
  assign out_last         = out_r.last;
  assign out_run_overflow = out_r.ovf;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overrun");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_end_of_stream |=> !started_r && run_len_r == '0 && !ovf_r)
    else $error("run state not cleared after end of stream");

  a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> out_code_length == LEN_W'(1) && !out_run_overflow && !out_last)
    else $error("malformed header beat");

endmodule
